@@ rtl/rri_pkg.sv @@
// Shared types and constants for the ray/rectangle intersection core.
package rri_pkg;

  localparam int Q_W       = 32;
  localparam int EXT_W     = 31;
  localparam int TOL_W     = 16;
  localparam int UV_W      = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // Four front stages, a numerator stage, then one register per quotient bit; the last is the output.
  localparam int FRONT_STG = 4;
  localparam int DIV_STEPS = 17;
  localparam int NUM_STG   = FRONT_STG + DIV_STEPS + 1;

  localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_TOL     = 2'd2;

  localparam logic [EXT_W-1:0] RECT_EXT_RST = 31'd65536;
  localparam logic [TOL_W-1:0] HIT_TOL_RST  = 16'd1;
  localparam logic [UV_W-1:0]  UV_ONE       = 17'd65536;

  typedef struct packed {
    logic signed [Q_W-1:0] origin_x;
    logic signed [Q_W-1:0] origin_y;
    logic signed [Q_W-1:0] origin_z;
    logic signed [Q_W-1:0] dir_x;
    logic signed [Q_W-1:0] dir_y;
    logic signed [Q_W-1:0] dir_z;
    logic signed [Q_W-1:0] inv_dir_y;
    logic signed [Q_W-1:0] t_min;
    logic signed [Q_W-1:0] t_max;
  } ray_in_t;

  typedef struct packed {
    logic                  hit;
    logic signed [Q_W-1:0] t_hit;
    logic signed [Q_W-1:0] hit_x;
    logic signed [Q_W-1:0] hit_z;
    logic [UV_W-1:0]       u_coord;
    logic [UV_W-1:0]       v_coord;
    logic                  front_side;
  } ray_out_t;

  // Result fields that ride along the divider stages.
  typedef struct packed {
    logic                  hit;
    logic signed [Q_W-1:0] t_hit;
    logic signed [Q_W-1:0] hit_x;
    logic signed [Q_W-1:0] hit_z;
    logic                  front_side;
  } hit_pl_t;

endpackage

@@ rtl/ray_rectangle_intersect_core.sv @@
// Ray against centered flat rectangle in the y = 0 plane, Q16.16 fixed point.
//
// Usage:
//   in_valid/in_ready/in_data carry one ray per transfer; out_valid/out_ready/
//   out_data return exactly one result per ray, in order. A miss returns hit = 0
//   with every other field zero.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write rect_height (0), rect_width (1)
//   and hit_tolerance (2); cfg_ready is always high. Write only while empty.
// Stages: four stages form t and the hit point (t multiply, bound test, x/z
//   multiply, origin add), one stage forms the u/v numerators, and the two
//   17-bit divisions retire one quotient bit per stage over 17 stages.
// Throughput: one ray per cycle without stalls. Each stage holds only when it
//   is full and the stage after it holds; bubbles are squeezed out in a stall.
// Receiver stall: out_data holds while out_valid is high and out_ready is low;
//   in_ready drops only once every stage is full.
// Reset: clears all stage valid bits and loads rect_height = rect_width = 1.0,
//   hit_tolerance = 1 LSB.
module ray_rectangle_intersect_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rri_pkg::ray_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rri_pkg::ray_out_t                   out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rri_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rri_pkg::CFG_DAT_W-1:0]       cfg_data
);
  import rri_pkg::*;

  // configuration
  logic [EXT_W-1:0] rect_h_r, rect_w_r;
  logic [TOL_W-1:0] hit_tol_r;

  // stage handshake
  logic [NUM_STG-1:0] vld_r;
  logic [NUM_STG-1:0] stg_rdy;

  // stage 0: t product
  logic signed [Q_W:0]     neg_oy;
  logic signed [2*Q_W:0]   ty_prod;
  logic signed [2*Q_W-1:0] s0_prod_r;
  ray_in_t                 s0_ray_r;

  // stage 1: bound test
  logic signed [47:0]      t_full;
  logic signed [48:0]      t_diff;
  logic                    t_ok;
  logic signed [Q_W-1:0]   s1_t_r;
  logic                    s1_hit_r;
  ray_in_t                 s1_ray_r;

  // stage 2: hit point products
  logic signed [2*Q_W-1:0] s2_xprod_r, s2_zprod_r;
  logic signed [Q_W-1:0]   s2_t_r;
  logic                    s2_hit_r;
  ray_in_t                 s2_ray_r;

  // stage 3: hit point
  logic signed [47:0]      x_off, z_off;
  logic signed [48:0]      s3_px_r, s3_pz_r;
  logic signed [Q_W-1:0]   s3_t_r;
  logic                    s3_hit_r, s3_front_r;

  // extent test and numerators (feeds divider slot 0)
  logic signed [49:0]      twice_px, twice_pz, h_s, w_s, num_x, num_z;
  logic                    x_in, z_in, hit4;

  // divider slots: slot 0 holds the numerators, slot k holds k quotient bits
  logic [Q_W-1:0]  dv_rem_u_r [0:DIV_STEPS];
  logic [Q_W-1:0]  dv_rem_v_r [0:DIV_STEPS];
  logic [UV_W-1:0] dv_q_u_r   [0:DIV_STEPS];
  logic [UV_W-1:0] dv_q_v_r   [0:DIV_STEPS];
  hit_pl_t         dv_pl_r    [0:DIV_STEPS];
  logic [Q_W-1:0]  dv_rem_u_nxt [0:DIV_STEPS];
  logic [Q_W-1:0]  dv_rem_v_nxt [0:DIV_STEPS];
  logic [UV_W-1:0] dv_q_u_nxt   [0:DIV_STEPS];
  logic [UV_W-1:0] dv_q_v_nxt   [0:DIV_STEPS];
  hit_pl_t         dv_pl_nxt    [0:DIV_STEPS];

  logic [Q_W:0] div_h, div_w;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_h_r  <= RECT_EXT_RST;
      rect_w_r  <= RECT_EXT_RST;
      hit_tol_r <= HIT_TOL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RECT_HEIGHT: rect_h_r  <= cfg_data[EXT_W-1:0];
        REG_RECT_WIDTH:  rect_w_r  <= cfg_data[EXT_W-1:0];
        REG_HIT_TOL:     hit_tol_r <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- handshake
  assign stg_rdy[NUM_STG-1] = ~vld_r[NUM_STG-1] | out_ready;
  for (genvar i = 0; i < NUM_STG - 1; i++) begin : g_rdy
    assign stg_rdy[i] = ~vld_r[i] | stg_rdy[i+1];
  end

  assign in_ready  = stg_rdy[0];
  assign out_valid = vld_r[NUM_STG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < NUM_STG; i++) begin
        if (stg_rdy[i]) vld_r[i] <= (i == 0) ? in_valid : vld_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  // ---------------------------------------------------------- front stages
  assign neg_oy  = -$signed({in_data.origin_y[Q_W-1], in_data.origin_y});
  assign ty_prod = neg_oy * in_data.inv_dir_y;

  assign t_full = s0_prod_r[63:16];
  assign t_diff = t_full - s0_ray_r.t_min;
  assign t_ok   = (s0_ray_r.dir_y != '0) && (t_full >= s0_ray_r.t_min) &&
                  (t_full <= s0_ray_r.t_max) && (t_diff >= $signed({33'd0, hit_tol_r}));

  assign x_off = s2_xprod_r[63:16];
  assign z_off = s2_zprod_r[63:16];

  always_ff @(posedge clk) begin
    if (stg_rdy[0]) begin
      s0_prod_r <= ty_prod[2*Q_W-1:0];
      s0_ray_r  <= in_data;
    end
    if (stg_rdy[1]) begin
      s1_t_r   <= t_full[Q_W-1:0];
      s1_hit_r <= t_ok;
      s1_ray_r <= s0_ray_r;
    end
    if (stg_rdy[2]) begin
      s2_xprod_r <= s1_ray_r.dir_x * s1_t_r;
      s2_zprod_r <= s1_ray_r.dir_z * s1_t_r;
      s2_t_r     <= s1_t_r;
      s2_hit_r   <= s1_hit_r;
      s2_ray_r   <= s1_ray_r;
    end
    if (stg_rdy[3]) begin
      s3_px_r    <= s2_ray_r.origin_x + x_off;
      s3_pz_r    <= s2_ray_r.origin_z + z_off;
      s3_t_r     <= s2_t_r;
      s3_hit_r   <= s2_hit_r;
      s3_front_r <= s2_ray_r.dir_y[Q_W-1] | (s2_ray_r.dir_y == '0);
    end
  end

  // Compare 2*p against the full extent so the half extent needs no rounding.
  assign twice_px = {s3_px_r, 1'b0};
  assign twice_pz = {s3_pz_r, 1'b0};
  assign h_s      = $signed({19'd0, rect_h_r});
  assign w_s      = $signed({19'd0, rect_w_r});
  assign x_in     = (twice_px >= -h_s) && (twice_px <= h_s);
  assign z_in     = (twice_pz >= -w_s) && (twice_pz <= w_s);
  assign hit4     = s3_hit_r && x_in && z_in;
  assign num_x    = twice_px + h_s;
  assign num_z    = twice_pz + w_s;

  // zero every field of a miss here; a zero numerator then divides to zero
  assign dv_rem_u_nxt[0]          = hit4 ? num_x[Q_W-1:0] : '0;
  assign dv_rem_v_nxt[0]          = hit4 ? num_z[Q_W-1:0] : '0;
  assign dv_q_u_nxt[0]            = '0;
  assign dv_q_v_nxt[0]            = '0;
  assign dv_pl_nxt[0].hit         = hit4;
  assign dv_pl_nxt[0].t_hit       = hit4 ? s3_t_r : '0;
  assign dv_pl_nxt[0].hit_x       = hit4 ? s3_px_r[Q_W-1:0] : '0;
  assign dv_pl_nxt[0].hit_z       = hit4 ? s3_pz_r[Q_W-1:0] : '0;
  assign dv_pl_nxt[0].front_side  = hit4 & s3_front_r;

  // --------------------------------------------------------------- divider
  // Divisor is twice the extent; remainder stays below it after every step.
  assign div_h = {1'b0, rect_h_r, 1'b0};
  assign div_w = {1'b0, rect_w_r, 1'b0};

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    logic [Q_W:0] trial_u, trial_v;
    logic         ge_u, ge_v;
    logic [Q_W:0] diff_u, diff_v;

    // first step weighs the integer bit, the rest shift in a zero each
    assign trial_u = (k == 1) ? {1'b0, dv_rem_u_r[k-1]} : {dv_rem_u_r[k-1], 1'b0};
    assign trial_v = (k == 1) ? {1'b0, dv_rem_v_r[k-1]} : {dv_rem_v_r[k-1], 1'b0};
    assign ge_u    = trial_u >= div_h;
    assign ge_v    = trial_v >= div_w;
    assign diff_u  = trial_u - div_h;
    assign diff_v  = trial_v - div_w;

    assign dv_rem_u_nxt[k] = ge_u ? diff_u[Q_W-1:0] : trial_u[Q_W-1:0];
    assign dv_rem_v_nxt[k] = ge_v ? diff_v[Q_W-1:0] : trial_v[Q_W-1:0];
    assign dv_pl_nxt[k]    = dv_pl_r[k-1];

    if (k == DIV_STEPS) begin : g_last
      // a zero extent reports its coordinate as zero
      assign dv_q_u_nxt[k] = (rect_h_r == '0) ? '0 : {dv_q_u_r[k-1][UV_W-2:0], ge_u};
      assign dv_q_v_nxt[k] = (rect_w_r == '0) ? '0 : {dv_q_v_r[k-1][UV_W-2:0], ge_v};
    end else begin : g_mid
      assign dv_q_u_nxt[k] = {dv_q_u_r[k-1][UV_W-2:0], ge_u};
      assign dv_q_v_nxt[k] = {dv_q_v_r[k-1][UV_W-2:0], ge_v};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= DIV_STEPS; k++) begin
      if (stg_rdy[FRONT_STG + k]) begin
        dv_rem_u_r[k] <= dv_rem_u_nxt[k];
        dv_rem_v_r[k] <= dv_rem_v_nxt[k];
        dv_q_u_r[k]   <= dv_q_u_nxt[k];
        dv_q_v_r[k]   <= dv_q_v_nxt[k];
        dv_pl_r[k]    <= dv_pl_nxt[k];
      end
    end
  end

  // ---------------------------------------------------------------- output
  assign out_data.hit        = dv_pl_r[DIV_STEPS].hit;
  assign out_data.t_hit      = dv_pl_r[DIV_STEPS].t_hit;
  assign out_data.hit_x      = dv_pl_r[DIV_STEPS].hit_x;
  assign out_data.hit_z      = dv_pl_r[DIV_STEPS].hit_z;
  assign out_data.u_coord    = dv_q_u_r[DIV_STEPS];
  assign out_data.v_coord    = dv_q_v_r[DIV_STEPS];
  assign out_data.front_side = dv_pl_r[DIV_STEPS].front_side;

  // -------------------------------------------------------------- checks
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.t_hit == '0 && out_data.hit_x == '0 &&
      out_data.hit_z == '0 && out_data.u_coord == '0 && out_data.v_coord == '0 &&
      !out_data.front_side)
    else $error("miss result carries nonzero fields");

  a_uv_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.u_coord <= UV_ONE && out_data.v_coord <= UV_ONE)
    else $error("parametric coordinate above one");

  a_zero_ext: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && rect_h_r == '0 |-> out_data.u_coord == '0)
    else $error("zero height must give zero u");

endmodule
